// File: rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  // Fixed field widths
  localparam int unsigned REQ_W      = 24;
  localparam int unsigned OFS_W      = 18;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned HDR_W      = 6;
  localparam int unsigned GRANT_W    = 13;
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned HDR_RESET  = 24;

  // Parameter defaults (powers of two)
  localparam int unsigned BLOCK_BYTES_DEF     = 64;
  localparam int unsigned HEAP_BLOCKS_MAX_DEF = 4096;
  localparam int unsigned MAX_EXTENTS_DEF     = 64;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BLOCKS  = 1'b0,
    REG_HEADER_BYTES = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REBUILD,
    S_SCAN,
    S_ALLOC_UPD,
    S_FREE_DEC,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic rebuild;
    logic scan;
    logic alloc_upd;
    logic free_dec;
    logic shift_dn;
    logic shift_up;
    logic post;
  } cmd_t;

  typedef struct packed {
    logic table_ready;
    logic op_free;
    logic scan_done;
    logic scan_hit;
    logic alloc_split;
    logic free_shift_dn;
    logic free_shift_up;
    logic shift_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/ffba_ram.sv
`default_nettype none

module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ffba_pkg::sts_t  sts_i,
  output ffba_pkg::cmd_t  cmd_o
);

  ffba_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        if (!sts_i.table_ready) begin
          state_d = ffba_pkg::S_REBUILD;
        end else if (in_valid_i) begin
          state_d = ffba_pkg::S_SCAN;
        end
      end
      ffba_pkg::S_REBUILD: state_d = ffba_pkg::S_IDLE;
      ffba_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.op_free) begin
            state_d = ffba_pkg::S_FREE_DEC;
          end else if (sts_i.scan_hit) begin
            state_d = ffba_pkg::S_ALLOC_UPD;
          end else begin
            state_d = ffba_pkg::S_RESP;
          end
        end
      end
      ffba_pkg::S_ALLOC_UPD: begin
        state_d = sts_i.alloc_split ? ffba_pkg::S_RESP : ffba_pkg::S_SHIFT_DN;
      end
      ffba_pkg::S_FREE_DEC: begin
        if (sts_i.free_shift_dn) begin
          state_d = ffba_pkg::S_SHIFT_DN;
        end else if (sts_i.free_shift_up) begin
          state_d = ffba_pkg::S_SHIFT_UP;
        end else begin
          state_d = ffba_pkg::S_RESP;
        end
      end
      ffba_pkg::S_SHIFT_DN,
      ffba_pkg::S_SHIFT_UP: begin
        if (sts_i.shift_done) begin
          state_d = ffba_pkg::S_RESP;
        end
      end
      ffba_pkg::S_RESP: begin
        if (!sts_i.out_busy) begin
          state_d = ffba_pkg::S_IDLE;
        end
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        in_ready_o   = sts_i.table_ready;
        cmd_o.accept = sts_i.table_ready & in_valid_i;
      end
      ffba_pkg::S_REBUILD:   cmd_o.rebuild   = 1'b1;
      ffba_pkg::S_SCAN:      cmd_o.scan      = 1'b1;
      ffba_pkg::S_ALLOC_UPD: cmd_o.alloc_upd = 1'b1;
      ffba_pkg::S_FREE_DEC:  cmd_o.free_dec  = 1'b1;
      ffba_pkg::S_SHIFT_DN:  cmd_o.shift_dn  = 1'b1;
      ffba_pkg::S_SHIFT_UP:  cmd_o.shift_up  = 1'b1;
      ffba_pkg::S_RESP:      cmd_o.post      = ~sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ffba_dp.sv
`default_nettype none

module ffba_dp #(
  parameter int unsigned BLOCK_BYTES     = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned HEAP_BLOCKS_MAX = ffba_pkg::HEAP_BLOCKS_MAX_DEF,
  parameter int unsigned MAX_EXTENTS     = ffba_pkg::MAX_EXTENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ffba_pkg::cmd_t                   cmd_i,
  output ffba_pkg::sts_t                   sts_o,
  input  logic                             op_i,
  input  logic [ffba_pkg::REQ_W-1:0]       request_bytes_i,
  input  logic [ffba_pkg::OFS_W-1:0]       release_offset_i,
  input  logic                             cfg_we_i,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [ffba_pkg::STATUS_W-1:0]    status_o,
  output logic [ffba_pkg::OFS_W-1:0]       user_offset_o,
  output logic [ffba_pkg::GRANT_W-1:0]     granted_blocks_o
);

  localparam int unsigned BB_SH   = $clog2(BLOCK_BYTES);
  localparam int unsigned HB_W    = $clog2(HEAP_BLOCKS_MAX);
  localparam int unsigned LEN_W   = HB_W + 1;
  localparam int unsigned ST_W    = LEN_W + 1;
  localparam int unsigned ENT_W   = ST_W + LEN_W;
  localparam int unsigned IDX_W   = $clog2(MAX_EXTENTS);
  localparam int unsigned CNT_W   = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned TOT_W   = ffba_pkg::REQ_W + 1;
  localparam int unsigned NEED_W  = TOT_W - BB_SH;
  localparam int unsigned LEN_CAP = 2 * HEAP_BLOCKS_MAX - 1;

  function automatic logic [LEN_W-1:0] sat_len(input logic [31:0] v);
    logic [31:0] c;
    c = (v > LEN_CAP) ? 32'(LEN_CAP) : v;
    return LEN_W'(c);
  endfunction

  // Control registers
  logic [LEN_W-1:0]               hb_q, hb_d;
  logic [ffba_pkg::HDR_W-1:0]     hdr_q, hdr_d;
  logic                           ready_q, ready_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [CNT_W-1:0]               ptr_q, ptr_d;
  logic                           vld_q, vld_d;
  logic                           out_valid_q, out_valid_d;

  // Payload registers
  logic                           op_q, op_d;
  logic [NEED_W-1:0]              need_q, need_d;
  logic [HB_W-1:0]                blk_q, blk_d;
  logic [CNT_W-1:0]               chk_q, chk_d;
  logic [CNT_W-1:0]               found_q, found_d;
  logic [ENT_W-1:0]               cur_q, cur_d;
  logic [ENT_W-1:0]               prev_q, prev_d;
  ffba_pkg::status_e              res_st_q, res_st_d, out_st_q, out_st_d;
  logic [ffba_pkg::OFS_W-1:0]     res_ofs_q, res_ofs_d, out_ofs_q, out_ofs_d;
  logic [ffba_pkg::GRANT_W-1:0]   res_blk_q, res_blk_d, out_blk_q, out_blk_d;

  // Memories
  logic              ext_we, ext_re;
  logic [IDX_W-1:0]  ext_waddr, ext_raddr;
  logic [ENT_W-1:0]  ext_wdata, ext_rdata;
  logic              g_we, g_re;
  logic [HB_W-1:0]   g_waddr, g_raddr;
  logic [LEN_W-1:0]  g_wdata, g_rdata;

  ffba_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EXTENTS)) u_ext_ram (
    .clk_i   (clk_i),
    .we_i    (ext_we),
    .waddr_i (ext_waddr),
    .wdata_i (ext_wdata),
    .re_i    (ext_re),
    .raddr_i (ext_raddr),
    .rdata_o (ext_rdata)
  );

  ffba_ram #(.WIDTH(LEN_W), .DEPTH(HEAP_BLOCKS_MAX)) u_grant_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (g_waddr),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (g_raddr),
    .rdata_o (g_rdata)
  );

  // Field views
  logic [ST_W-1:0]  r_start, cur_start, prev_start;
  logic [LEN_W-1:0] r_len, cur_len, prev_len;
  assign r_start    = ext_rdata[ENT_W-1:LEN_W];
  assign r_len      = ext_rdata[LEN_W-1:0];
  assign cur_start  = cur_q[ENT_W-1:LEN_W];
  assign cur_len    = cur_q[LEN_W-1:0];
  assign prev_start = prev_q[ENT_W-1:LEN_W];
  assign prev_len   = prev_q[LEN_W-1:0];

  // Request decode
  logic [TOT_W-1:0]           tot;
  logic [NEED_W-1:0]          need_raw, need_in;
  logic [ffba_pkg::OFS_W-1:0] dofs;
  logic [HB_W-1:0]            blk_in;
  assign tot      = TOT_W'(request_bytes_i) + TOT_W'(hdr_q) + TOT_W'(BLOCK_BYTES - 1);
  assign need_raw = NEED_W'(tot >> BB_SH);
  assign need_in  = (need_raw == '0) ? NEED_W'(1) : need_raw;
  assign dofs     = release_offset_i - ffba_pkg::OFS_W'(hdr_q);
  assign blk_in   = HB_W'(32'(dofs) >> BB_SH);

  // Scan and shift conditions
  logic scan_hit, scan_end, dn_rd, up_rd, dn_done, up_done;
  assign scan_hit = vld_q && (op_q ? (32'(r_start) >= 32'(blk_q))
                                   : (32'(r_len) >= 32'(need_q)));
  assign scan_end = !scan_hit && (vld_q ? (32'(chk_q) + 32'd1 == 32'(count_q))
                                        : (count_q == '0));
  assign dn_rd    = ptr_q < count_q;
  assign up_rd    = ptr_q > found_q;
  assign dn_done  = !dn_rd && !vld_q;
  assign up_done  = !up_rd && !vld_q;

  // Free decision
  logic jn, jp, full, glen_zero, alloc_split;
  assign glen_zero   = g_rdata == '0;
  assign jn   = (found_q < count_q) && (32'(blk_q) + 32'(g_rdata) == 32'(cur_start));
  assign jp   = (found_q != '0) && (32'(prev_start) + 32'(prev_len) == 32'(blk_q));
  assign full = 32'(count_q) >= MAX_EXTENTS;
  assign alloc_split = 32'(cur_len) > 32'(need_q);

  logic [31:0] hb_cfg;
  assign hb_cfg = 32'(cfg_wdata_i);

  always_comb begin
    hb_d = hb_q; hdr_d = hdr_q; ready_d = ready_q; count_d = count_q;
    ptr_d = ptr_q; vld_d = vld_q; out_valid_d = out_valid_q;
    op_d = op_q; need_d = need_q; blk_d = blk_q; chk_d = chk_q; found_d = found_q;
    cur_d = cur_q; prev_d = prev_q;
    res_st_d = res_st_q; res_ofs_d = res_ofs_q; res_blk_d = res_blk_q;
    out_st_d = out_st_q; out_ofs_d = out_ofs_q; out_blk_d = out_blk_q;
    ext_we = 1'b0; ext_waddr = '0; ext_wdata = '0; ext_re = 1'b0; ext_raddr = '0;
    g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_re = 1'b0; g_raddr = '0;

    if (cmd_i.rebuild) begin
      ext_we    = 1'b1;
      ext_wdata = {ST_W'(0), hb_q};
      count_d   = CNT_W'(1);
      ready_d   = 1'b1;
    end

    if (cmd_i.accept) begin
      op_d    = op_i;
      need_d  = need_in;
      blk_d   = blk_in;
      ptr_d   = '0;
      vld_d   = 1'b0;
      g_re    = 1'b1;
      g_raddr = blk_in;
    end

    if (cmd_i.scan) begin
      ext_re    = dn_rd;
      ext_raddr = ptr_q[IDX_W-1:0];
      if (dn_rd) ptr_d = ptr_q + CNT_W'(1);
      chk_d = ptr_q;
      vld_d = dn_rd;
      if (vld_q && !scan_hit) prev_d = ext_rdata;
      if (scan_hit || scan_end) begin
        found_d = scan_hit ? chk_q : count_q;
        cur_d   = ext_rdata;
        if (!op_q && !scan_hit) begin
          res_st_d  = ffba_pkg::ST_NO_FIT;
          res_ofs_d = '0;
          res_blk_d = '0;
        end
      end
    end

    if (cmd_i.alloc_upd) begin
      g_we      = 1'b1;
      g_waddr   = cur_start[HB_W-1:0];
      g_wdata   = LEN_W'(need_q);
      res_st_d  = ffba_pkg::ST_OK;
      res_ofs_d = ffba_pkg::OFS_W'((32'(cur_start) << BB_SH) + 32'(hdr_q));
      res_blk_d = ffba_pkg::GRANT_W'(need_q);
      if (alloc_split) begin
        ext_we    = 1'b1;
        ext_waddr = found_q[IDX_W-1:0];
        ext_wdata = {ST_W'(32'(cur_start) + 32'(need_q)),
                     LEN_W'(32'(cur_len) - 32'(need_q))};
      end else begin
        ptr_d = found_q + CNT_W'(1);
        vld_d = 1'b0;
      end
    end

    if (cmd_i.free_dec) begin
      res_st_d  = ffba_pkg::ST_OK;
      res_ofs_d = '0;
      res_blk_d = ffba_pkg::GRANT_W'(g_rdata);
      if (glen_zero) begin
        res_blk_d = '0;
      end else if (jn && jp) begin
        ext_we    = 1'b1;
        ext_waddr = IDX_W'(found_q - CNT_W'(1));
        ext_wdata = {prev_start,
                     sat_len(32'(prev_len) + 32'(g_rdata) + 32'(cur_len))};
        ptr_d = found_q + CNT_W'(1);
        vld_d = 1'b0;
      end else if (jp) begin
        ext_we    = 1'b1;
        ext_waddr = IDX_W'(found_q - CNT_W'(1));
        ext_wdata = {prev_start, sat_len(32'(prev_len) + 32'(g_rdata))};
      end else if (jn) begin
        ext_we    = 1'b1;
        ext_waddr = found_q[IDX_W-1:0];
        ext_wdata = {ST_W'(blk_q), sat_len(32'(cur_len) + 32'(g_rdata))};
      end else if (full) begin
        res_st_d  = ffba_pkg::ST_TABLE_FULL;
        res_blk_d = '0;
      end else begin
        ptr_d = count_q;
        vld_d = 1'b0;
      end
    end

    // Close the gap: move entry k+1 down to k
    if (cmd_i.shift_dn) begin
      ext_re    = dn_rd;
      ext_raddr = ptr_q[IDX_W-1:0];
      if (dn_rd) ptr_d = ptr_q + CNT_W'(1);
      chk_d = ptr_q;
      vld_d = dn_rd;
      if (vld_q) begin
        ext_we    = 1'b1;
        ext_waddr = IDX_W'(chk_q - CNT_W'(1));
        ext_wdata = ext_rdata;
      end
      if (dn_done) count_d = count_q - CNT_W'(1);
    end

    // Open a gap at the insert point, then drop the new extent in
    if (cmd_i.shift_up) begin
      ext_re    = up_rd;
      ext_raddr = IDX_W'(ptr_q - CNT_W'(1));
      if (up_rd) ptr_d = ptr_q - CNT_W'(1);
      chk_d = ptr_q - CNT_W'(1);
      vld_d = up_rd;
      if (vld_q) begin
        ext_we    = 1'b1;
        ext_waddr = IDX_W'(chk_q + CNT_W'(1));
        ext_wdata = ext_rdata;
      end else if (up_done) begin
        ext_we    = 1'b1;
        ext_waddr = found_q[IDX_W-1:0];
        ext_wdata = {ST_W'(blk_q), g_rdata};
        count_d   = count_q + CNT_W'(1);
      end
    end

    if (cmd_i.post) begin
      out_valid_d = 1'b1;
      out_st_d    = res_st_q;
      out_ofs_d   = res_ofs_q;
      out_blk_d   = res_blk_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ffba_pkg::REG_HEAP_BLOCKS: begin
          if (hb_cfg == 32'd0) begin
            hb_d = LEN_W'(1);
          end else if (hb_cfg > HEAP_BLOCKS_MAX) begin
            hb_d = LEN_W'(HEAP_BLOCKS_MAX);
          end else begin
            hb_d = LEN_W'(hb_cfg);
          end
          ready_d = 1'b0;
        end
        ffba_pkg::REG_HEADER_BYTES: hdr_d = cfg_wdata_i[ffba_pkg::HDR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_q        <= LEN_W'(HEAP_BLOCKS_MAX);
      hdr_q       <= ffba_pkg::HDR_W'(ffba_pkg::HDR_RESET);
      ready_q     <= 1'b0;
      count_q     <= CNT_W'(1);
      ptr_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      hb_q        <= hb_d;
      hdr_q       <= hdr_d;
      ready_q     <= ready_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    need_q    <= need_d;
    blk_q     <= blk_d;
    chk_q     <= chk_d;
    found_q   <= found_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    res_st_q  <= res_st_d;
    res_ofs_q <= res_ofs_d;
    res_blk_q <= res_blk_d;
    out_st_q  <= out_st_d;
    out_ofs_q <= out_ofs_d;
    out_blk_q <= out_blk_d;
  end

  assign sts_o.table_ready   = ready_q;
  assign sts_o.op_free       = op_q;
  assign sts_o.scan_done     = scan_hit | scan_end;
  assign sts_o.scan_hit      = scan_hit;
  assign sts_o.alloc_split   = alloc_split;
  assign sts_o.free_shift_dn = !glen_zero && jn && jp;
  assign sts_o.free_shift_up = !glen_zero && !jn && !jp && !full;
  assign sts_o.shift_done    = cmd_i.shift_dn ? dn_done : up_done;
  assign sts_o.out_busy      = out_valid_q & ~out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign user_offset_o    = out_ofs_q;
  assign granted_blocks_o = out_blk_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_EXTENTS)
    else $error("extent count above table depth");

  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ext_we && ext_re) |-> (ext_waddr != ext_raddr))
    else $error("extent shift reads and writes one entry");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_up |-> (32'(count_q) < MAX_EXTENTS))
    else $error("insert into full extent table");

  a_post_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.post |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites pending transfer");

endmodule

`default_nettype wire

// File: rtl/first_fit_block_allocator.sv
// First-fit block allocator with a coalescing, address-sorted free-extent table.
//
// Input channel (in_valid_i/in_ready_o): op_i = 0 allocates request_bytes_i
// bytes (plus the header, rounded up to whole blocks); op_i = 1 frees the grant
// whose user offset is release_offset_i. Each transfer yields exactly one result
// on the output channel (out_valid_o/out_ready_i): status, user offset, blocks.
// Sequencing: an item walks the extent table one entry per cycle through the
// single read port of the extent RAM, then shifts entries one per cycle on a
// removal or insertion. One item is in flight at a time.
// The result sits in an output register; once it is loaded, the next item is
// taken while the receiver stalls, and its result waits until the slot frees.
// Reset, and every write of heap_blocks, leave the table stale; it is rebuilt
// as a single extent in the REBUILD state before the next item is accepted.
// Recorded grant sizes are never cleared. BLOCK_BYTES and HEAP_BLOCKS_MAX are
// powers of two. Configuration writes (cfg_we_i) take effect at once.
`default_nettype none

module first_fit_block_allocator #(
  parameter int unsigned BLOCK_BYTES     = ffba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned HEAP_BLOCKS_MAX = ffba_pkg::HEAP_BLOCKS_MAX_DEF,
  parameter int unsigned MAX_EXTENTS     = ffba_pkg::MAX_EXTENTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [ffba_pkg::REQ_W-1:0]      request_bytes_i,
  input  logic [ffba_pkg::OFS_W-1:0]      release_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ffba_pkg::STATUS_W-1:0]   status_o,
  output logic [ffba_pkg::OFS_W-1:0]      user_offset_o,
  output logic [ffba_pkg::GRANT_W-1:0]    granted_blocks_o,
  input  logic                            cfg_we_i,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  ffba_pkg::cmd_t cmd;
  ffba_pkg::sts_t sts;

  // Sequence scan, update and shift phases
  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Extent table, grant sizes, config and result registers
  ffba_dp #(
    .BLOCK_BYTES     (BLOCK_BYTES),
    .HEAP_BLOCKS_MAX (HEAP_BLOCKS_MAX),
    .MAX_EXTENTS     (MAX_EXTENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .request_bytes_i  (request_bytes_i),
    .release_offset_i (release_offset_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .user_offset_o    (user_offset_o),
    .granted_blocks_o (granted_blocks_o)
  );

endmodule

`default_nettype wire

// File: bench/ffba_checker.sv
`timescale 1ns / 100ps

module ffba_checker
  import ffba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  op_i,
  input  logic [REQ_W-1:0]      request_bytes_i,
  input  logic [OFS_W-1:0]      release_offset_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [STATUS_W-1:0]   status_i,
  input  logic [OFS_W-1:0]      user_offset_i,
  input  logic [GRANT_W-1:0]    granted_blocks_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned BLK_BYTES = BLOCK_BYTES_DEF;
  localparam int unsigned HEAP_MAX  = HEAP_BLOCKS_MAX_DEF;
  localparam int unsigned EXT_MAX   = MAX_EXTENTS_DEF;
  localparam int unsigned LEN_CAP   = 2 * HEAP_MAX - 1;

  typedef struct packed {
    status_e            st;
    logic [OFS_W-1:0]   uofs;
    logic [GRANT_W-1:0] blocks;
  } outcome_t;

  outcome_t    outcome_q[$];
  int unsigned ext_start [EXT_MAX];
  int unsigned ext_len [EXT_MAX];
  int unsigned ext_cnt;
  int unsigned grant_len [HEAP_MAX];
  int unsigned heap_cnt;
  int unsigned hdr;
  bit          stale;

  function automatic int unsigned cap_len(int unsigned v);
    return (v > LEN_CAP) ? LEN_CAP : v;
  endfunction

  function automatic void drop_extent(int unsigned idx);
    for (int unsigned k = idx; k + 1 < ext_cnt; k++) begin
      ext_start[k] = ext_start[k + 1];
      ext_len[k]   = ext_len[k + 1];
    end
    ext_cnt--;
  endfunction

  // Advance the free-extent table by one item and return its outcome.
  function automatic outcome_t apply_item(logic op, logic [REQ_W-1:0] req,
                                          logic [OFS_W-1:0] rel);
    outcome_t    res;
    int unsigned i, p, need, s, d, blk, len;
    bit          jn, jp;
    res = '{st: ST_OK, uofs: '0, blocks: '0};
    if (stale) begin
      ext_start[0] = 0;
      ext_len[0]   = heap_cnt;
      ext_cnt      = 1;
      stale        = 0;
    end
    if (!op) begin
      need = (int'(req) + hdr + BLK_BYTES - 1) / BLK_BYTES;
      if (need == 0) need = 1;
      for (i = 0; i < ext_cnt; i++) if (ext_len[i] >= need) break;
      if (i >= ext_cnt) begin
        res.st = ST_NO_FIT;
        return res;
      end
      s = ext_start[i];
      if (ext_len[i] > need) begin
        ext_start[i] = s + need;
        ext_len[i]   = ext_len[i] - need;
      end else begin
        drop_extent(i);
      end
      grant_len[s % HEAP_MAX] = need;
      res.uofs   = OFS_W'(s * BLK_BYTES + hdr);
      res.blocks = GRANT_W'(need);
      return res;
    end
    d   = (int'(rel) - hdr) & ((1 << OFS_W) - 1);
    blk = (d / BLK_BYTES) % HEAP_MAX;
    len = grant_len[blk];
    if (len == 0) return res;
    for (p = 0; p < ext_cnt; p++) if (ext_start[p] >= blk) break;
    jn = (p < ext_cnt) && (blk + len == ext_start[p]);
    jp = (p > 0) && (ext_start[p - 1] + ext_len[p - 1] == blk);
    if (jn && jp) begin
      ext_len[p - 1] = cap_len(ext_len[p - 1] + len + ext_len[p]);
      drop_extent(p);
    end else if (jp) begin
      ext_len[p - 1] = cap_len(ext_len[p - 1] + len);
    end else if (jn) begin
      ext_start[p] = blk;
      ext_len[p]   = cap_len(ext_len[p] + len);
    end else begin
      if (ext_cnt >= EXT_MAX) begin
        res.st = ST_TABLE_FULL;
        return res;
      end
      for (i = ext_cnt; i > p; i--) begin
        ext_start[i] = ext_start[i - 1];
        ext_len[i]   = ext_len[i - 1];
      end
      ext_start[p] = blk;
      ext_len[p]   = len;
      ext_cnt++;
    end
    res.blocks = GRANT_W'(len);
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    int unsigned v;
    if (!rst_ni) begin
      outcome_q.delete();
      fail_count_o = 0;
      heap_cnt     = HEAP_MAX;
      hdr          = HDR_RESET;
      stale        = 1;
      foreach (grant_len[k]) grant_len[k] = 0;
    end else begin
      // Compare the outgoing transfer first, so it never meets this edge's new item.
      if (out_valid_i && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t result with nothing outstanding", $realtime);
          fail_count_o++;
        end else begin
          want = outcome_q.pop_front();
          if (status_i != want.st) report_mismatch("status", status_i, want.st);
          if (user_offset_i != want.uofs)
            report_mismatch("user_offset", user_offset_i, want.uofs);
          if (granted_blocks_i != want.blocks)
            report_mismatch("granted_blocks", granted_blocks_i, want.blocks);
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_HEAP_BLOCKS) begin
          v = cfg_wdata_i;
          if (v < 1) v = 1;
          if (v > HEAP_MAX) v = HEAP_MAX;
          heap_cnt = v;
          stale    = 1;
        end else begin
          hdr = cfg_wdata_i[HDR_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i)
        outcome_q.push_back(apply_item(op_i, request_bytes_i, release_offset_i));
    end
    pending_o = outcome_q.size();
  end

endmodule

// File: bench/first_fit_block_allocator_tb.sv
`timescale 1ns / 100ps

module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int unsigned BLK_BYTES   = BLOCK_BYTES_DEF;
  localparam int unsigned HEAP_MAX    = HEAP_BLOCKS_MAX_DEF;
  localparam int          DRAIN_WAIT  = 2 * MAX_EXTENTS_DEF + 10;
  localparam int          CYCLE_LIMIT = 3000000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  op_i = 1'b0;
  logic [REQ_W-1:0]      request_bytes_i = '0;
  logic [OFS_W-1:0]      release_offset_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [OFS_W-1:0]      user_offset_o;
  logic [GRANT_W-1:0]    granted_blocks_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_HEAP_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int cycles = 0;

  // Stimulus bookkeeping: grants that are still held, and every block that ever got one.
  int unsigned live_blk[$];
  int unsigned touched_blk[$];
  bit          touched [HEAP_MAX];
  bit          op_pend[$];
  int unsigned cur_hdr = HDR_RESET;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          n_alloc = 0, n_free = 0, n_nofit = 0, n_full = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  first_fit_block_allocator uut (.*);

  ffba_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .request_bytes_i, .release_offset_i,
    .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .user_offset_i(user_offset_o), .granted_blocks_i(granted_blocks_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none at all while idling is off.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: hold out_ready low for random stretches.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  <= pick_gap();
    end
  end

  // Learn granted blocks from the result stream so frees only name recorded grants.
  always @(posedge clk_i) begin
    bit          was_free;
    int unsigned blk;
    if (in_valid_i && in_ready_o) op_pend.push_back(op_i);
    if (out_valid_o && out_ready_i && op_pend.size() > 0) begin
      was_free = op_pend.pop_front();
      if (status_o == ST_NO_FIT) n_nofit++;
      else if (status_o == ST_TABLE_FULL) n_full++;
      else if (was_free) n_free++;
      else begin
        n_alloc++;
        blk = ((user_offset_o - cur_hdr) / BLK_BYTES) % HEAP_MAX;
        live_blk.push_back(blk);
        if (!touched[blk]) begin
          touched[blk] = 1'b1;
          touched_blk.push_back(blk);
        end
      end
    end
  end

  // Present one item and hold it until the transfer.
  task automatic send_item(bit op, logic [REQ_W-1:0] req, logic [OFS_W-1:0] rel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    request_bytes_i  <= req;
    release_offset_i <= rel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [OFS_W-1:0] offset_of(int unsigned blk);
    return OFS_W'(blk * BLK_BYTES + cur_hdr + $urandom_range(0, BLK_BYTES - 1));
  endfunction

  task automatic alloc_bytes(logic [REQ_W-1:0] req);
    send_item(1'b0, req, OFS_W'($urandom_range(0, (1 << OFS_W) - 1)));
  endtask

  task automatic free_block(int unsigned blk);
    send_item(1'b1, REQ_W'($urandom()), offset_of(blk));
  endtask

  task automatic random_items(int count);
    int r, k;
    logic [REQ_W-1:0] req;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 40 && live_blk.size() > 0) begin
        k = $urandom_range(0, live_blk.size() - 1);
        free_block(live_blk[k]);
        live_blk.delete(k);
      end else if (r < 46 && touched_blk.size() > 0) begin
        // Double or stale free: not detected by the block, merged anyway.
        free_block(touched_blk[$urandom_range(0, touched_blk.size() - 1)]);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70)      req = $urandom_range(0, 300);
        else if (r < 85) req = $urandom_range(0, 4000);
        else if (r < 95) req = $urandom_range(0, 70000);
        else             req = REQ_W'($urandom());
        alloc_bytes(req);
      end
    end
  endtask

  // Drop valid, wait out every result and the tail of the last item.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic set_heap(int unsigned heap, int unsigned hdr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_HEAP_BLOCKS;
    cfg_wdata_i <= CFG_DATA_W'(heap);
    @(posedge clk_i);
    cfg_index_i <= REG_HEADER_BYTES;
    cfg_wdata_i <= CFG_DATA_W'(hdr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_hdr = hdr;
    live_blk.delete();
    @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: whole heap, oversized request, wrap of a free below the header.
    idle_on = 1'b0;
    alloc_bytes(HEAP_MAX * BLK_BYTES - HDR_RESET);
    alloc_bytes('0);
    send_item(1'b1, '0, OFS_W'(HDR_RESET));
    alloc_bytes((HEAP_MAX - 1) * BLK_BYTES - HDR_RESET);
    alloc_bytes('0);
    send_item(1'b1, '0, OFS_W'(5));
    send_item(1'b1, '0, OFS_W'(HDR_RESET + 63));
    alloc_bytes({REQ_W{1'b1}});
    idle_on = 1'b1;
    // Fill the extent table with isolated holes until it overflows, then bridge two.
    for (int b = 0; b < 130; b++) alloc_bytes('0);
    for (int b = 0; b <= 126; b += 2) send_item(1'b1, '0, OFS_W'(b * BLK_BYTES + HDR_RESET));
    send_item(1'b1, '0, OFS_W'(BLK_BYTES + HDR_RESET));
    drain();
    random_items(400);
    drain();

    // Heap size is clamped both ways; header sweeps its range.
    set_heap(8191, 0);
    alloc_bytes('0);
    random_items(300);
    drain();
    set_heap(0, 63);
    random_items(150);
    drain();
    set_heap(100, 40);
    random_items(300);
    drain();
    set_heap(4096, 63);
    random_items(350);
    drain();
    set_heap(37, 7);
    random_items(250);
    drain();

    $display("covered %0d grants, %0d releases, %0d no-fit, %0d table-full over six settings",
             n_alloc, n_free, n_nofit, n_full);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator.sv
bench/ffba_checker.sv
bench/first_fit_block_allocator_tb.sv
